FILE: hw/rtl/csl_pkg.sv
package csl_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } lex_in_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_offset;
        logic [30:0] token_value;
        logic [15:0] token_length;
        logic        last_of_run;
    } lex_out_t;

    typedef enum logic [3:0] {
        M_START,
        M_HELD,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_CHAR_FIRST,
        M_CHAR_SKIP,
        M_LINE,
        M_BLOCK,
        M_STAR,
        M_ERROR
    } lex_mode_t;

    localparam logic [5:0]  K_DOUBLE_BASE = 6'd17;
    localparam logic [5:0]  K_KEYWORD_BASE = 6'd27;
    localparam logic [5:0]  K_NUM   = 6'd35;
    localparam logic [5:0]  K_STR   = 6'd36;
    localparam logic [5:0]  K_IDENT = 6'd37;
    localparam logic [5:0]  K_EOF   = 6'd38;
    localparam logic [5:0]  K_ERR   = 6'd39;
    localparam logic [5:0]  K_NONE  = 6'd63;
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
    localparam logic [15:0] RUN_MAX = 16'hFFFF;
    localparam int          KW_COUNT = 8;
    localparam int          KW_CHARS = 8;

    // keyword text, first character in the low byte
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
        {16'h0, "nruter"},
        {16'h0, "foezis"},
        {24'h0, "elihw"},
        {32'h0, "rahc"},
        {32'h0, "esle"},
        {40'h0, "tni"},
        {40'h0, "rof"},
        {48'h0, "fi"}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd3, 4'd2};

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        logic [5:0] k;
        k = K_NONE;
        unique case (b)
            "+": k = 6'd0;
            "-": k = 6'd1;
            "*": k = 6'd2;
            "/": k = 6'd3;
            "%": k = 6'd4;
            ")": k = 6'd5;
            "(": k = 6'd6;
            "<": k = 6'd7;
            ">": k = 6'd8;
            "=": k = 6'd9;
            ";": k = 6'd10;
            "{": k = 6'd11;
            "}": k = 6'd12;
            ",": k = 6'd13;
            "&": k = 6'd14;
            "[": k = 6'd15;
            "]": k = 6'd16;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic can_pair(input logic [7:0] b);
        return b == "=" || b == "!" || b == "<" || b == ">" || b == "&" ||
               b == "|" || b == "+" || b == "-" || b == "*" || b == "/";
    endfunction

    function automatic logic [5:0] double_kind(input logic [7:0] h, input logic [7:0] b);
        logic [5:0] k;
        k = K_NONE;
        if (b == "=") begin
            unique case (h)
                "=": k = K_DOUBLE_BASE;
                "!": k = K_DOUBLE_BASE + 6'd1;
                "<": k = K_DOUBLE_BASE + 6'd2;
                ">": k = K_DOUBLE_BASE + 6'd3;
                "+": k = K_DOUBLE_BASE + 6'd6;
                "-": k = K_DOUBLE_BASE + 6'd7;
                "*": k = K_DOUBLE_BASE + 6'd8;
                "/": k = K_DOUBLE_BASE + 6'd9;
                default: k = K_NONE;
            endcase
        end else if (h == "&" && b == "&") begin
            k = K_DOUBLE_BASE + 6'd4;
        end else if (h == "|" && b == "|") begin
            k = K_DOUBLE_BASE + 6'd5;
        end
        return k;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || is_digit(b) || b == "_";
    endfunction

endpackage

FILE: hw/rtl/c_subset_lexer_unit.sv
// Byte-serial lexer for a small C subset. One source byte (or an end-of-text
// marker) is taken per request; the lexer state registers are updated in the
// same cycle and each request yields zero, one or two tokens (kind, start
// offset, value, length), the last one flagged with last_of_run. Tokens go into
// a four-entry output queue and leave it in order. A request is taken in every
// cycle while the queue has room for two tokens: sustained rate is one byte per
// cycle; a run of bytes that each yield two tokens (a closing token plus a
// one-character operator, an error token or the end token) is held to the
// output rate of one token per cycle. Whitespace and comments are skipped,
// numbers saturate at 2^31-1, and after an error all bytes are dropped until
// the end marker, which returns the lexer to reset.
module c_subset_lexer_unit #(
    parameter int MAX_TEXT_LENGTH    = 65536,
    parameter int KEYWORD_MAX_LENGTH = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  csl_pkg::lex_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output csl_pkg::lex_out_t out_data
);
    import csl_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT_LENGTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT_LENGTH - 1);

    // lexer state
    lex_mode_t        mode_reg, mode_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       prefix_reg [KEYWORD_MAX_LENGTH];
    logic [15:0]      run_reg, run_next;
    logic [30:0]      acc_reg, acc_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // output queue
    lex_out_t   q_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg, cnt_next;

    logic       in_acc, out_acc;
    logic [7:0] b;
    logic       pfx_we;

    // token slots: close of the current token, then a follow-on token
    logic       close_v, follow_v;
    lex_out_t   close_tok, follow_tok;
    lex_out_t   push0, push1;
    logic [1:0] push_n;

    // start_byte outcome
    lex_mode_t        sb_mode;
    logic             sb_emit;
    lex_out_t         sb_tok;
    logic             sb_set_start, sb_pfx, sb_acc, sb_run, sb_held;

    // keyword lookup
    logic [KW_CHARS*8-1:0] pfx_flat;
    logic [5:0]            word_kind;
    logic                  kw_hit;

    // number step
    logic [34:0] prod;
    logic [30:0] acc_step;

    logic [15:0] start16, pos16;
    logic [5:0]  held_single, dbl;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign b       = in_data.text_byte;
    assign start16 = 16'(start_reg);
    assign pos16   = 16'(pos_reg);
    assign held_single = single_kind(held_reg);
    assign dbl     = double_kind(held_reg, b);

    always_comb
    begin
        pfx_flat = '0;
        for (int j = 0; j < KEYWORD_MAX_LENGTH && j < KW_CHARS; j++)
        begin
            pfx_flat[j*8 +: 8] = prefix_reg[j];
        end
    end

    always_comb
    begin
        logic same;
        kw_hit = 1'b0;
        word_kind = K_IDENT;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            same = (run_reg == 16'(KW_LEN[k]));
            for (int i = 0; i < KW_CHARS; i++)
            begin
                if (i < int'(KW_LEN[k]) && pfx_flat[i*8 +: 8] != KW_TEXT[k][i*8 +: 8])
                    same = 1'b0;
            end
            if (same && !kw_hit)
            begin
                kw_hit = 1'b1;
                word_kind = K_KEYWORD_BASE + 6'(k);
            end
        end
    end

    always_comb
    begin
        prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 35'(b - "0");
        acc_step = (prod > 35'(NUM_MAX)) ? NUM_MAX : prod[30:0];
    end

    // what a byte does at the start of a token
    always_comb
    begin
        sb_mode = M_START;
        sb_emit = 1'b0;
        sb_tok = '0;
        sb_set_start = 1'b0;
        sb_pfx = 1'b0;
        sb_acc = 1'b0;
        sb_run = 1'b0;
        sb_held = 1'b0;
        if (!is_space(b))
        begin
            sb_set_start = 1'b1;
            sb_tok.start_offset = pos16;
            if (b == "\"")
            begin
                sb_mode = M_STRING;
                sb_run = 1'b1;
            end else if (b == "'")
            begin
                sb_mode = M_CHAR_FIRST;
            end else if (is_digit(b))
            begin
                sb_mode = M_NUMBER;
                sb_acc = 1'b1;
            end else if (is_word(b))
            begin
                sb_mode = M_IDENT;
                sb_run = 1'b1;
                sb_pfx = 1'b1;
            end else if (can_pair(b))
            begin
                sb_mode = M_HELD;
                sb_held = 1'b1;
            end else if (single_kind(b) != K_NONE)
            begin
                sb_emit = 1'b1;
                sb_tok.token_kind = single_kind(b);
            end else
            begin
                sb_emit = 1'b1;
                sb_tok.token_kind = K_ERR;
                sb_mode = M_ERROR;
            end
        end
    end

    // one request: state update and up to two tokens
    always_comb
    begin
        logic do_sb;
        do_sb = 1'b0;
        mode_next = mode_reg;
        held_next = held_reg;
        run_next = run_reg;
        acc_next = acc_reg;
        start_next = start_reg;
        pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        pfx_we = 1'b0;
        close_v = 1'b0;
        close_tok = '0;
        close_tok.start_offset = start16;
        follow_v = 1'b0;
        follow_tok = '0;
        if (in_data.end_of_text)
        begin
            follow_tok.token_kind = K_EOF;
            follow_tok.start_offset = pos16;
            unique case (mode_reg)
                M_HELD:
                begin
                    close_v = 1'b1;
                    close_tok.token_kind = (held_single == K_NONE) ? K_ERR : held_single;
                    follow_v = (held_single != K_NONE);
                end
                M_IDENT:
                begin
                    close_v = 1'b1;
                    close_tok.token_kind = word_kind;
                    close_tok.token_length = kw_hit ? 16'd0 : run_reg;
                    follow_v = 1'b1;
                end
                M_NUMBER:
                begin
                    close_v = 1'b1;
                    close_tok.token_kind = K_NUM;
                    close_tok.token_value = acc_reg;
                    follow_v = 1'b1;
                end
                M_STRING, M_CHAR_FIRST, M_CHAR_SKIP, M_BLOCK, M_STAR:
                begin
                    close_v = 1'b1;
                    close_tok.token_kind = K_ERR;
                end
                M_ERROR: ;
                default: follow_v = 1'b1;
            endcase
            mode_next = M_START;
            held_next = '0;
            run_next = '0;
            acc_next = '0;
            start_next = '0;
            pos_next = '0;
        end else
        begin
            unique case (mode_reg)
                M_HELD:
                begin
                    if (held_reg == "/" && b == "/")
                        mode_next = M_LINE;
                    else if (held_reg == "/" && b == "*")
                        mode_next = M_BLOCK;
                    else if (dbl != K_NONE)
                    begin
                        close_v = 1'b1;
                        close_tok.token_kind = dbl;
                        mode_next = M_START;
                    end else if (held_single == K_NONE)
                    begin
                        close_v = 1'b1;
                        close_tok.token_kind = K_ERR;
                        mode_next = M_ERROR;
                    end else
                    begin
                        close_v = 1'b1;
                        close_tok.token_kind = held_single;
                        do_sb = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_word(b))
                    begin
                        pfx_we = (run_reg < 16'(KEYWORD_MAX_LENGTH));
                        if (run_reg != RUN_MAX)
                            run_next = run_reg + 16'd1;
                    end else
                    begin
                        close_v = 1'b1;
                        close_tok.token_kind = word_kind;
                        close_tok.token_length = kw_hit ? 16'd0 : run_reg;
                        do_sb = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(b))
                        acc_next = acc_step;
                    else
                    begin
                        close_v = 1'b1;
                        close_tok.token_kind = K_NUM;
                        close_tok.token_value = acc_reg;
                        do_sb = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (b == "\"")
                    begin
                        close_v = 1'b1;
                        close_tok.token_kind = K_STR;
                        close_tok.token_length = run_reg;
                        mode_next = M_START;
                    end else if (run_reg != RUN_MAX)
                        run_next = run_reg + 16'd1;
                end
                M_CHAR_FIRST:
                begin
                    if (b == "'")
                    begin
                        close_v = 1'b1;
                        close_tok.token_kind = K_ERR;
                        close_tok.start_offset = pos16;
                        mode_next = M_ERROR;
                    end else
                    begin
                        acc_next = 31'(b);
                        mode_next = M_CHAR_SKIP;
                    end
                end
                M_CHAR_SKIP:
                begin
                    if (b == "'")
                    begin
                        close_v = 1'b1;
                        close_tok.token_kind = K_NUM;
                        close_tok.token_value = acc_reg;
                        mode_next = M_START;
                    end
                end
                M_LINE:  if (b == 8'h0A) mode_next = M_START;
                M_BLOCK: if (b == "*") mode_next = M_STAR;
                M_STAR:
                begin
                    if (b == "/")
                        mode_next = M_START;
                    else if (b != "*")
                        mode_next = M_BLOCK;
                end
                M_ERROR: ;
                default: do_sb = 1'b1;
            endcase
            if (do_sb)
            begin
                mode_next = sb_mode;
                follow_v = sb_emit;
                follow_tok = sb_tok;
                if (sb_set_start) start_next = pos_reg;
                if (sb_acc) acc_next = 31'(b - "0");
                if (sb_run) run_next = (sb_mode == M_IDENT) ? 16'd1 : 16'd0;
                if (sb_held) held_next = b;
                pfx_we = sb_pfx;
            end
        end
    end

    // pack the tokens into queue slots, last one flagged
    always_comb
    begin
        push0 = close_v ? close_tok : follow_tok;
        push1 = follow_tok;
        push_n = 2'(close_v) + 2'(follow_v);
        push0.last_of_run = (push_n == 2'd1);
        push1.last_of_run = 1'b1;
    end

    assign in_ready  = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + (in_acc ? 3'(push_n) : 3'd0) - (out_acc ? 3'd1 : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            held_reg  <= '0;
            run_reg   <= '0;
            acc_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            cnt_reg   <= '0;
        end else
        begin
            if (in_acc)
            begin
                mode_reg  <= mode_next;
                held_reg  <= held_next;
                run_reg   <= run_next;
                acc_reg   <= acc_next;
                start_reg <= start_next;
                pos_reg   <= pos_next;
                wr_reg    <= wr_reg + push_n;
            end
            if (out_acc)
                rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    // prefix bytes: written at the current word length
    always_ff @(posedge clk)
    begin
        if (in_acc && pfx_we)
        begin
            for (int j = 0; j < KEYWORD_MAX_LENGTH; j++)
            begin
                if (run_next == 16'(j + 1))
                    prefix_reg[j] <= b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && push_n != 2'd0)
            q_reg[wr_reg] <= push0;
        if (in_acc && push_n == 2'd2)
            q_reg[wr_reg + 2'd1] <= push1;
    end

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("token queue overflow");

    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_data.end_of_text) |=> (pos_reg == '0 && mode_reg == M_START))
        else $error("end marker did not reset lexer");

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && mode_reg == M_ERROR) |-> (push_n == 2'd0))
        else $error("token produced while in error mode");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && push_n != 2'd0 && mode_next == M_ERROR && !in_data.end_of_text)
        |-> ((push_n == 2'd1 ? push0.token_kind : push1.token_kind) == K_ERR))
        else $error("error mode entered without error token");
`endif

endmodule

FILE: tb/tb_c_subset_lexer_unit.sv
module tb_c_subset_lexer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import csl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_MISMATCH_SHOW = 10;
    localparam int KW_MAX = 6;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    lex_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    lex_out_t out_data;

    c_subset_lexer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // expected tokens, oldest first
    lex_out_t  token_queue [$];
    int        mismatch_count;
    int        idle_cycles;
    bit        timed_out;

    // sender pacing: idle cycles before the next request, valid left high
    int        next_gap;
    bit        valid_held;

    // lexer state mirror
    lex_mode_t   mode_q;
    logic [7:0]  held_q;
    logic [7:0]  prefix_q [KW_MAX];
    logic [15:0] run_q;
    logic [30:0] acc_q;
    logic [15:0] start_q;
    logic [15:0] pos_q;
    int          n_tokens;

    // keyword spellings in kind order
    string kw_words [8] = '{"return", "sizeof", "while", "char", "else", "int", "for", "if"};

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // token prediction
    // ---------------------------------------------------------------
    function automatic bit blank_byte(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit digit_byte(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit word_byte(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || digit_byte(b) || b == "_";
    endfunction

    function automatic int op_single(logic [7:0] b);
        string ops;
        ops = "+-*/%)(<>=;{},&[]";
        for (int i = 0; i < 17; i++)
            if (ops[i] == b) return i;
        return -1;
    endfunction

    function automatic int op_double(logic [7:0] h, logic [7:0] b);
        string firsts;
        string seconds;
        firsts  = "=!<>&|+-*/";
        seconds = "====&|====";
        for (int i = 0; i < 10; i++)
            if (firsts[i] == h && seconds[i] == b) return i;
        return -1;
    endfunction

    function automatic bit pair_opener(logic [7:0] b);
        string firsts;
        firsts = "=!<>&|+-*/";
        for (int i = 0; i < 10; i++)
            if (firsts[i] == b) return 1;
        return 0;
    endfunction

    task automatic push_token(logic [5:0] kind, logic [15:0] at, logic [30:0] val,
                              logic [15:0] len);
        lex_out_t t;
        t.token_kind   = kind;
        t.start_offset = at;
        t.token_value  = val;
        t.token_length = len;
        t.last_of_run  = 1'b0;
        token_queue.push_back(t);
        n_tokens++;
    endtask

    task automatic flag_error(logic [15:0] at);
        push_token(K_ERR, at, '0, '0);
        mode_q = M_ERROR;
    endtask

    task automatic finish_word();
        logic [5:0] kind;
        bit same;
        kind = K_IDENT;
        if (run_q <= KW_MAX) begin
            for (int k = 0; k < 8 && kind == K_IDENT; k++) begin
                same = (kw_words[k].len() == run_q);
                for (int i = 0; same && i < run_q; i++)
                    if (kw_words[k][i] != prefix_q[i]) same = 0;
                if (same) kind = K_KEYWORD_BASE + 6'(k);
            end
        end
        if (kind == K_IDENT) push_token(K_IDENT, start_q, '0, run_q);
        else push_token(kind, start_q, '0, '0);
        mode_q = M_START;
    endtask

    task automatic finish_held();
        int s;
        s = op_single(held_q);
        if (s < 0) flag_error(start_q);
        else
        begin
            push_token(6'(s), start_q, '0, '0);
            mode_q = M_START;
        end
    endtask

    task automatic open_token(logic [7:0] b, logic [15:0] at);
        int s;
        mode_q = M_START;
        if (blank_byte(b)) return;
        start_q = at;
        if (b == "\"")
        begin
            mode_q = M_STRING;
            run_q = '0;
        end
        else if (b == "'") mode_q = M_CHAR_FIRST;
        else if (digit_byte(b))
        begin
            mode_q = M_NUMBER;
            acc_q = 31'(b - "0");
        end
        else if (word_byte(b))
        begin
            mode_q = M_IDENT;
            run_q = 16'd1;
            prefix_q[0] = b;
        end
        else if (pair_opener(b))
        begin
            mode_q = M_HELD;
            held_q = b;
        end
        else
        begin
            s = op_single(b);
            if (s >= 0) push_token(6'(s), at, '0, '0);
            else flag_error(at);
        end
    endtask

    task automatic predict_end();
        case (mode_q)
            M_HELD:
            begin
                finish_held();
                if (mode_q != M_ERROR) push_token(K_EOF, pos_q, '0, '0);
            end
            M_IDENT:
            begin
                finish_word();
                push_token(K_EOF, pos_q, '0, '0);
            end
            M_NUMBER:
            begin
                push_token(K_NUM, start_q, acc_q, '0);
                push_token(K_EOF, pos_q, '0, '0);
            end
            M_STRING, M_CHAR_FIRST, M_CHAR_SKIP, M_BLOCK, M_STAR: flag_error(start_q);
            M_ERROR: ;
            default: push_token(K_EOF, pos_q, '0, '0);
        endcase
        mode_q  = M_START;
        held_q  = '0;
        run_q   = '0;
        acc_q   = '0;
        start_q = '0;
        pos_q   = '0;
    endtask

    task automatic predict_byte(logic [7:0] b);
        logic [15:0] at;
        logic [30:0] d;
        int dk;
        at = pos_q;
        case (mode_q)
            M_HELD:
            begin
                dk = op_double(held_q, b);
                if (held_q == "/" && b == "/") mode_q = M_LINE;
                else if (held_q == "/" && b == "*") mode_q = M_BLOCK;
                else if (dk >= 0)
                begin
                    push_token(K_DOUBLE_BASE + 6'(dk), start_q, '0, '0);
                    mode_q = M_START;
                end
                else
                begin
                    finish_held();
                    if (mode_q != M_ERROR) open_token(b, at);
                end
            end
            M_IDENT:
                if (word_byte(b))
                begin
                    if (run_q < KW_MAX) prefix_q[run_q] = b;
                    if (run_q != RUN_MAX) run_q++;
                end
                else
                begin
                    finish_word();
                    open_token(b, at);
                end
            M_NUMBER:
                if (digit_byte(b))
                begin
                    d = 31'(b - "0");
                    if (acc_q > (NUM_MAX - d) / 10) acc_q = NUM_MAX;
                    else acc_q = acc_q * 10 + d;
                end
                else
                begin
                    push_token(K_NUM, start_q, acc_q, '0);
                    open_token(b, at);
                end
            M_STRING:
                if (b == "\"")
                begin
                    push_token(K_STR, start_q, '0, run_q);
                    mode_q = M_START;
                end
                else if (run_q != RUN_MAX) run_q++;
            M_CHAR_FIRST:
                if (b == "'") flag_error(at);
                else
                begin
                    acc_q = 31'(b);
                    mode_q = M_CHAR_SKIP;
                end
            M_CHAR_SKIP:
                if (b == "'")
                begin
                    push_token(K_NUM, start_q, acc_q, '0);
                    mode_q = M_START;
                end
            M_LINE:  if (b == 8'h0A) mode_q = M_START;
            M_BLOCK: if (b == "*") mode_q = M_STAR;
            M_STAR:
                if (b == "/") mode_q = M_START;
                else if (b != "*") mode_q = M_BLOCK;
            M_ERROR: ;
            default: open_token(b, at);
        endcase
        pos_q = pos_q + 16'd1;
    endtask

    // works out the tokens of one request and marks the last of them
    task automatic predict_tokens(lex_in_t req);
        n_tokens = 0;
        if (req.end_of_text) predict_end();
        else predict_byte(req.text_byte);
        if (n_tokens > 0) token_queue[$].last_of_run = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // sending side
    // ---------------------------------------------------------------
    // valid stays high into the next request when it follows with no gap
    task automatic send_request(logic [7:0] b, logic eot);
        lex_in_t req;
        repeat (next_gap) @(posedge clk);
        req.text_byte   = b;
        req.end_of_text = eot;
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_tokens(req);
        next_gap = $urandom_range(0, 3);
        valid_held = (next_gap == 0);
        if (!valid_held) in_valid <= 1'b0;
    endtask

    // drop valid when no request follows right away
    task automatic release_input();
        if (valid_held)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_request(8'h00, 1'b1);
    endtask

    // sender holds off until the lexer has drained every token
    task automatic wait_drained();
        release_input();
        while (token_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // receiving side: random stall per token, check against oldest
    // ---------------------------------------------------------------
    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (token_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_MISMATCH_SHOW)
                    $display("unexpected token: kind %0d at %0d", out_data.token_kind,
                             out_data.start_offset);
            end
            else
            begin
                lex_out_t want;
                want = token_queue.pop_front();
                if (out_data !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_MISMATCH_SHOW)
                        $display("mismatch: expected kind %0d off %0d val %0d len %0d last %0b,",
                                 want.token_kind, want.start_offset, want.token_value,
                                 want.token_length, want.last_of_run,
                                 " got kind %0d off %0d val %0d len %0d last %0b",
                                 out_data.token_kind, out_data.start_offset,
                                 out_data.token_value, out_data.token_length,
                                 out_data.last_of_run);
                end
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_operators();
        send_text("+-*/%)(<>=;{},&[] == != <= >= && || += -= *= /= ");
        send_text("+ - * / < > = & ");
        send_end();
    endtask

    task automatic test_keywords_and_words();
        send_text("return sizeof while char else int for if ");
        send_text("returns iff _x9 Z ");
        send_end();
    endtask

    task automatic test_numbers_and_constants();
        send_text("0 2147483647 99999999999 'a' 'xyz' '");
        send_request(8'hFF, 1'b0);
        send_text("' \"\" \"ab\"");
        send_text("12");
        send_end();
    endtask

    task automatic test_comments_and_space();
        send_text("a//c\n\t\v\f\rb/*x**/c/**/");
        send_text("x//tail");
        send_end();
    endtask

    task automatic test_errors();
        // empty char constant
        send_text("'' junk");
        send_end();
        // lone bang then lone bar
        send_text("!a");
        send_end();
        send_text("|");
        send_end();
        // zero byte
        send_request(8'h00, 1'b0);
        send_end();
        // unclosed forms at the end marker
        send_text("/* open");
        send_end();
        send_text("\"open");
        send_end();
        send_text("'q");
        send_end();
        send_end();
    endtask

    function automatic logic [7:0] pick_byte();
        string alphabet;
        int r;
        alphabet = "abcdefghijklmnopqrstuvwxyz_ZQ0123456789+-*/%()<>=;{},&[]!|'\" \n\t";
        r = $urandom_range(0, 99);
        if (r < 5) return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    task automatic test_random_text();
        int sent;
        int r;
        int w;
        bit drained;
        sent = 0;
        drained = 1'b0;
        while (sent < 220)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                w = $urandom_range(0, 7);
                send_text(kw_words[w]);
                send_text(" ");
                sent += kw_words[w].len() + 1;
            end
            else if (r < 22)
            begin
                send_text("/*");
                send_request(pick_byte(), 1'b0);
                send_text("*/");
                sent += 5;
            end
            else
            begin
                send_request(pick_byte(), 1'b0);
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
            begin
                send_end();
                sent++;
            end
            // once, partway through, a pause until every token has drained
            if (sent >= 100 && !drained)
            begin
                wait_drained();
                drained = 1'b1;
            end
        end
        send_end();
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        next_gap = 0;
        valid_held = 1'b0;
        mode_q = M_START;
        held_q = '0;
        run_q = '0;
        acc_q = '0;
        start_q = '0;
        pos_q = '0;
        for (int i = 0; i < KW_MAX; i++) prefix_q[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operators();
        test_keywords_and_words();
        test_numbers_and_constants();
        test_comments_and_space();
        test_errors();
        wait_drained();
        test_random_text();
        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && token_queue.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
